// ===== rtl/core/cvl_pkg.sv =====
// Shared constants, codes and types of the compacting value list.
`timescale 1ns / 1ps

package cvl_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int KIND_W = 3;
    localparam int SLOT_W = 4;
    localparam int STAT_W = 3;
    localparam int ENTRY_W = 5;

    localparam logic [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH         = 3'd0,
        KIND_POP          = 3'd1,
        KIND_REMOVE_AT    = 3'd2,
        KIND_REMOVE_MATCH = 3'd3,
        KIND_READ         = 3'd4
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_RANGE     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        status_t           status;
        logic [CNT_W-1:0]  count;
    } result_t;

endpackage

// ===== rtl/core/cvl_mem.sv =====
// Entry storage of the list: one write port and one registered read port.
`timescale 1ns / 1ps

module cvl_mem
(
    input  logic                        clk,
    input  cvl_pkg::mem_req_t           req,
    output logic [cvl_pkg::DATA_W-1:0]  rd_data
);

    logic [cvl_pkg::DATA_W-1:0] mem [cvl_pkg::DEPTH];
    logic [cvl_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/cvl_seq.sv =====
// Sequencer that runs each list operation over the storage with one value comparator for remove by match.
`timescale 1ns / 1ps

module cvl_seq
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cvl_pkg::KIND_W-1:0]    kind,
    input  logic [cvl_pkg::SLOT_W-1:0]    slot,
    input  logic [cvl_pkg::DATA_W-1:0]    data,
    output cvl_pkg::mem_req_t             mem_req,
    input  logic [cvl_pkg::DATA_W-1:0]    rd_data,
    output logic                          res_done,
    input  logic                          res_take,
    output cvl_pkg::result_t              res
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DECODE   = 8'b0000_0010,
        S_GRAB     = 8'b0000_0100,
        S_TAKE     = 8'b0000_1000,
        S_SCAN     = 8'b0001_0000,
        S_SHIFT_RD = 8'b0010_0000,
        S_SHIFT_WR = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    state_t                       state_reg, state_next;
    logic [cvl_pkg::KIND_W-1:0]   kind_reg, kind_next;
    logic [cvl_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [cvl_pkg::DATA_W-1:0]   data_reg, data_next;
    logic [cvl_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [cvl_pkg::CNT_W-1:0]    ptr_reg, ptr_next;
    logic [cvl_pkg::DATA_W-1:0]   val_reg, val_next;
    cvl_pkg::status_t             stat_reg, stat_next;

    logic [cvl_pkg::CNT_W-1:0]    slot_ext;
    logic [cvl_pkg::CNT_W-1:0]    ptr_inc;
    logic [cvl_pkg::CNT_W-1:0]    last_pos;
    logic                         match;

    assign slot_ext = cvl_pkg::CNT_W'(slot_reg);
    assign ptr_inc  = cvl_pkg::CNT_W'(ptr_reg + 1'b1);
    assign last_pos = cvl_pkg::CNT_W'(count_reg - 1'b1);
    assign match    = (rd_data == data_reg);

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        slot_next  = slot_reg;
        data_next  = data_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        val_next   = val_reg;
        stat_next  = stat_reg;
        in_ready   = 1'b0;
        res_done   = 1'b0;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = ptr_reg[cvl_pkg::IDX_W-1:0];
        mem_req.wr_data = rd_data;
        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = ptr_inc[cvl_pkg::IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    kind_next  = kind;
                    slot_next  = slot;
                    data_next  = data;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                val_next   = '0;
                stat_next  = cvl_pkg::ST_OK;
                state_next = S_DONE;
                unique case (cvl_pkg::kind_t'(kind_reg))
                    cvl_pkg::KIND_PUSH:
                    begin
                        if (count_reg == cvl_pkg::CNT_W'(cvl_pkg::DEPTH))
                        begin
                            stat_next = cvl_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = count_reg[cvl_pkg::IDX_W-1:0];
                            mem_req.wr_data = data_reg;
                            count_next      = cvl_pkg::CNT_W'(count_reg + 1'b1);
                        end
                    end
                    cvl_pkg::KIND_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            val_next  = cvl_pkg::INT_MIN;
                            stat_next = cvl_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = last_pos[cvl_pkg::IDX_W-1:0];
                            count_next      = last_pos;
                            state_next      = S_GRAB;
                        end
                    end
                    cvl_pkg::KIND_READ:
                    begin
                        if (slot_ext >= count_reg)
                        begin
                            stat_next = cvl_pkg::ST_RANGE;
                        end
                        else
                        begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = slot_ext[cvl_pkg::IDX_W-1:0];
                            state_next      = S_GRAB;
                        end
                    end
                    cvl_pkg::KIND_REMOVE_AT:
                    begin
                        if (slot_ext >= count_reg)
                        begin
                            stat_next = cvl_pkg::ST_RANGE;
                        end
                        else
                        begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = slot_ext[cvl_pkg::IDX_W-1:0];
                            ptr_next        = slot_ext;
                            state_next      = S_TAKE;
                        end
                    end
                    cvl_pkg::KIND_REMOVE_MATCH:
                    begin
                        if (count_reg == '0)
                        begin
                            stat_next = cvl_pkg::ST_NOT_FOUND;
                        end
                        else
                        begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = '0;
                            ptr_next        = '0;
                            state_next      = S_SCAN;
                        end
                    end
                    default:
                    begin
                        stat_next = cvl_pkg::ST_OK;
                    end
                endcase
            end
            S_GRAB:
            begin
                val_next   = rd_data;
                state_next = S_DONE;
            end
            S_TAKE:
            begin
                val_next   = rd_data;
                state_next = S_SHIFT_RD;
            end
            S_SCAN:
            begin
                if (match)
                begin
                    val_next   = rd_data;
                    state_next = S_SHIFT_RD;
                end
                else if (ptr_inc == count_reg)
                begin
                    stat_next  = cvl_pkg::ST_NOT_FOUND;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_req.rd_en = 1'b1;
                    ptr_next      = ptr_inc;
                end
            end
            S_SHIFT_RD:
            begin
                if (ptr_inc >= count_reg)
                begin
                    count_next = last_pos;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_req.rd_en = 1'b1;
                    state_next    = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                mem_req.wr_en = 1'b1;
                ptr_next      = ptr_inc;
                state_next    = S_SHIFT_RD;
            end
            S_DONE:
            begin
                res_done = 1'b1;
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        slot_reg <= slot_next;
        data_reg <= data_next;
        ptr_reg  <= ptr_next;
        val_reg  <= val_next;
        stat_reg <= stat_next;
    end

    assign res.value  = val_reg;
    assign res.status = stat_reg;
    assign res.count  = count_reg;

endmodule

// ===== rtl/core/compacting_value_list_unit.sv =====
// Top level of the compacting value list with its result output register.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_ready  kind, slot, data
//   out      output     out_valid/out_ready  result_value, status, entry_count
//
// Push, pop, read and unused kinds pass through the decode and done states, with a grab
// state between them when a pop or read fetches an entry from the storage.
// A match remove scans entries one by one; any remove moves each later entry down by
// a shift read and a shift write, set by the single read and write port of the storage.
// The block accepts a new beat only when the previous operation has moved into the
// output register, which holds its beat while out_ready is low.
// Reset empties the list at once; entries are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module compacting_value_list_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [cvl_pkg::KIND_W-1:0]          kind,
    input  logic [cvl_pkg::SLOT_W-1:0]          slot,
    input  logic signed [cvl_pkg::DATA_W-1:0]   data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [cvl_pkg::DATA_W-1:0]   result_value,
    output logic [cvl_pkg::STAT_W-1:0]          status,
    output logic [cvl_pkg::ENTRY_W-1:0]         entry_count
);

    cvl_pkg::mem_req_t              mem_req;
    logic [cvl_pkg::DATA_W-1:0]     rd_data;
    logic                           res_done;
    logic                           res_take;
    cvl_pkg::result_t               res;

    logic                           out_valid_reg, out_valid_next;
    logic [cvl_pkg::DATA_W-1:0]     value_reg, value_next;
    logic [cvl_pkg::STAT_W-1:0]     status_reg, status_next;
    logic [cvl_pkg::ENTRY_W-1:0]    count_reg, count_next;

    cvl_mem u_mem
    (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    cvl_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .slot     (slot),
        .data     (data),
        .mem_req  (mem_req),
        .rd_data  (rd_data),
        .res_done (res_done),
        .res_take (res_take),
        .res      (res)
    );

    assign res_take = res_done && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        count_next     = count_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            value_next     = res.value;
            status_next    = res.status;
            count_next     = cvl_pkg::ENTRY_W'(res.count);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        status_reg <= status_next;
        count_reg  <= count_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_value = value_reg;
    assign status       = status_reg;
    assign entry_count  = count_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res.count <= cvl_pkg::CNT_W'(cvl_pkg::DEPTH))
        else $error("fill count exceeds capacity");

    a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !res_done)
        else $error("input taken while a result is pending");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == cvl_pkg::ST_EMPTY) |->
        (result_value == cvl_pkg::INT_MIN && entry_count == '0))
        else $error("empty status with wrong value or count");

    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == cvl_pkg::ST_FULL) |->
        (entry_count == cvl_pkg::ENTRY_W'(cvl_pkg::DEPTH)))
        else $error("full status while list not full");
`endif

endmodule
